/* rtl/arc_pkg.sv */
// Types, constants and helper functions shared by the aligned ring allocator.
package arc_pkg;

   // Widths of the offsets and of the running counters.
   localparam int OFS_BITS = 25;
   localparam int CNT_BITS = 32;
   localparam int SHIFT_BITS = 4;
   localparam int MODE_BITS = 2;
   localparam int ADDR_BITS = 3;

   // Ring size after reset.
   localparam logic [OFS_BITS-1:0] RING_RESET = OFS_BITS'(25'd16777216);

   // Register index carried by the word-address bit of paddr.
   localparam logic REG_RING_SIZE = 1'b0;

   // Request modes.
   localparam logic [MODE_BITS-1:0] MODE_ALLOC  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RESET  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DEFRAG = 2'd2;

   // One request item.
   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [OFS_BITS-1:0]   request_size;
      logic [SHIFT_BITS-1:0] align_shift;
   } req_type;

   // One result item.
   typedef struct packed {
      logic                granted;
      logic [OFS_BITS-1:0] region_offset;
      logic [CNT_BITS-1:0] wasted_bytes;
      logic [CNT_BITS-1:0] wrap_count;
      logic [OFS_BITS-1:0] free_bytes;
      logic                frag_critical;
      logic                under_pressure;
   } rsp_type;

   // Pipeline handshake between the top level and the allocator state.
   typedef struct packed {
      logic fire;
   } step_ctrl_type;

   // Add two counter values and stop at the all-ones value.
   function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                   input logic [CNT_BITS-1:0] b);
      logic [CNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CNT_BITS] ? {CNT_BITS{1'b1}} : sum[CNT_BITS-1:0];
   endfunction

   // Waste is critical when twice the waste exceeds a nonzero ring size.
   function automatic logic is_critical(input logic [CNT_BITS-1:0] waste,
                                        input logic [OFS_BITS-1:0] ring);
      return (ring != '0) && ({waste, 1'b0} > (CNT_BITS+1)'(ring));
   endfunction

endpackage

/* rtl/arc_csr.sv */
// Configuration register block holding the ring size.
module arc_csr
   import arc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output logic [OFS_BITS-1:0]  ring_size
);

   logic [OFS_BITS-1:0] ring_size_ff;
   logic [OFS_BITS-1:0] ring_size_in;
   logic                wr_en;

   // A write lands in the access phase; only the word-address bit selects a register.
   assign wr_en = psel && penable && pwrite && (paddr[2] == REG_RING_SIZE);

   always_comb begin
      ring_size_in = ring_size_ff;
      if (wr_en) begin
         ring_size_in = pwdata[OFS_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_RESET;
      end else begin
         ring_size_ff <= ring_size_in;
      end
   end

   // Read back the register; other addresses read as zero.
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_RING_SIZE) begin
         prdata = 32'(ring_size_ff);
      end
   end

   assign pready    = 1'b1;
   assign ring_size = ring_size_ff;

endmodule

/* rtl/arc_alloc.sv */
// Allocator state and the combinational next-state and result logic.
module arc_alloc
   import arc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  step_ctrl_type       ctrl,
   input  req_type             item,
   input  logic [OFS_BITS-1:0] ring_size,
   output rsp_type             result
);

   logic [OFS_BITS-1:0] wp_ff, wp_in;
   logic [CNT_BITS-1:0] waste_ff, waste_in;
   logic [CNT_BITS-1:0] wraps_ff, wraps_in;
   logic [OFS_BITS-1:0] free_ff, free_in;
   logic [CNT_BITS-1:0] reqcnt_ff, reqcnt_in;
   logic [CNT_BITS-1:0] failcnt_ff, failcnt_in;

   logic [15:0]         align_m1;
   logic [OFS_BITS:0]   aligned;
   logic [OFS_BITS:0]   pad;
   logic [OFS_BITS+1:0] end_first;
   logic                fit_first;
   logic                fit_zero;
   logic [OFS_BITS-1:0] tail;
   logic [CNT_BITS-1:0] waste_wrap;
   logic [CNT_BITS-1:0] wraps_wrap;
   logic                crit_now;
   logic                crit_fail;
   logic                crit_out;
   logic [CNT_BITS+3:0] fail_x10;
   logic                granted;
   logic [OFS_BITS-1:0] offset;

   // Round the pointer up to the alignment and see whether the region fits.
   always_comb begin
      align_m1  = (16'd1 << item.align_shift) - 16'd1;
      aligned   = ({1'b0, wp_ff} + (OFS_BITS+1)'(align_m1)) & ~((OFS_BITS+1)'(align_m1));
      pad       = aligned - {1'b0, wp_ff};
      end_first = {1'b0, aligned} + (OFS_BITS+2)'(item.request_size);
      fit_first = end_first <= (OFS_BITS+2)'(ring_size);
      fit_zero  = item.request_size <= ring_size;
      tail      = (ring_size > wp_ff) ? (ring_size - wp_ff) : '0;
      waste_wrap = sat_add(waste_ff, CNT_BITS'(tail));
      wraps_wrap = sat_add(wraps_ff, CNT_BITS'(1));
      crit_now   = is_critical(waste_ff, ring_size);
      crit_fail  = is_critical(waste_wrap, ring_size);
   end

   // Next state for each mode.
   always_comb begin
      wp_in      = wp_ff;
      waste_in   = waste_ff;
      wraps_in   = wraps_ff;
      free_in    = free_ff;
      reqcnt_in  = reqcnt_ff;
      failcnt_in = failcnt_ff;
      granted    = 1'b0;
      offset     = '0;
      case (item.mode)
         MODE_ALLOC: begin
            reqcnt_in = sat_add(reqcnt_ff, CNT_BITS'(1));
            if (fit_first) begin
               // Fits at the aligned pointer; the padding is waste.
               waste_in = sat_add(waste_ff, CNT_BITS'(pad));
               wp_in    = end_first[OFS_BITS-1:0];
               free_in  = ring_size - end_first[OFS_BITS-1:0];
               granted  = 1'b1;
               offset   = aligned[OFS_BITS-1:0];
            end else if (fit_zero) begin
               // Wrapped to the start of the ring and fits there.
               waste_in = waste_wrap;
               wraps_in = wraps_wrap;
               wp_in    = item.request_size;
               free_in  = ring_size - item.request_size;
               granted  = 1'b1;
            end else if (crit_fail) begin
               // Failed; the ring is cleared and the retry at pointer zero
               // fails the same way, wrapping the whole ring once.
               waste_in   = CNT_BITS'(ring_size);
               wraps_in   = CNT_BITS'(1);
               wp_in      = '0;
               free_in    = ring_size;
               failcnt_in = sat_add(failcnt_ff, CNT_BITS'(2));
            end else begin
               // Failed after wrapping; the wrap stays counted.
               waste_in   = waste_wrap;
               wraps_in   = wraps_wrap;
               wp_in      = '0;
               failcnt_in = sat_add(failcnt_ff, CNT_BITS'(1));
            end
         end
         MODE_RESET: begin
            waste_in = '0;
            wraps_in = '0;
            wp_in    = '0;
            free_in  = ring_size;
         end
         MODE_DEFRAG: begin
            if (crit_now) begin
               waste_in = '0;
               wraps_in = '0;
               wp_in    = '0;
               free_in  = ring_size;
               granted  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Status flags from the state after this item.
   always_comb begin
      crit_out = is_critical(waste_in, ring_size);
      fail_x10 = ((CNT_BITS+4)'(failcnt_in) << 3) + ((CNT_BITS+4)'(failcnt_in) << 1);
      result.granted        = granted;
      result.region_offset  = offset;
      result.wasted_bytes   = waste_in;
      result.wrap_count     = wraps_in;
      result.free_bytes     = free_in;
      result.frag_critical  = crit_out;
      result.under_pressure = (reqcnt_in != '0) &&
                              ((fail_x10 > (CNT_BITS+4)'(reqcnt_in)) || crit_out);
   end

   // State registers advance once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         waste_ff   <= '0;
         wraps_ff   <= '0;
         free_ff    <= RING_RESET;
         reqcnt_ff  <= '0;
         failcnt_ff <= '0;
      end else if (ctrl.fire) begin
         wp_ff      <= wp_in;
         waste_ff   <= waste_in;
         wraps_ff   <= wraps_in;
         free_ff    <= free_in;
         reqcnt_ff  <= reqcnt_in;
         failcnt_ff <= failcnt_in;
      end
   end

endmodule

/* rtl/aligned_ring_allocator_core.sv */
// Top level of the aligned ring allocator: input and result registers around the allocator.
//
// Each request item is captured in an input register, processed by the combinational
// allocator logic, and its single result item is held in a result register until taken.
// One item is accepted per cycle unless the result side stalls, and each result is
// registered as its item leaves the input register; the limit is the loop from the write
// pointer and counters back to themselves. The input register can still take one item
// while a result waits, so a stalled result side holds at most two items. The ring size
// register resets to 16777216 bytes and is to be written only while no item is in flight.
module aligned_ring_allocator_core
   import arc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic                in_valid_ff, in_valid_in;
   req_type             in_data_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff;
   logic                advance;
   step_ctrl_type       ctrl;
   rsp_type             result;
   logic [OFS_BITS-1:0] ring_size;

   arc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .ring_size (ring_size)
   );

   arc_alloc u_alloc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .item      (in_data_ff),
      .ring_size (ring_size),
      .result    (result)
   );

   // The stage moves when the result register is empty or being read.
   assign advance   = !out_valid_ff || rsp_ready;
   assign ctrl.fire = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   // Valid flags of the two registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (ctrl.fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
